>>> rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the scheduler core.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property holds at every clock edge outside reset
`define LETS_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("scheduler assertion failed");

// consequent holds in the cycle after the antecedent
`define LETS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("scheduler assertion failed");

`endif

>>> rtl/core/lets_pkg.sv
// ----------------------------------------------------------------------------
// Scheduler package
// Codes, command types and defaults shared by the scheduler core.
// ----------------------------------------------------------------------------
package lets_pkg;

  localparam int LETS_MAX_THREADS  = 16;
  localparam int LETS_ELAPSED_BITS = 16;

  localparam logic [1:0] FN_CREATE = 2'd0;
  localparam logic [1:0] FN_SCHED  = 2'd1;
  localparam logic [1:0] FN_EXIT   = 2'd2;
  localparam logic [1:0] FN_JOIN   = 2'd3;

  localparam logic [1:0] ST_RUN     = 2'd0;
  localparam logic [1:0] ST_BLOCK   = 2'd1;
  localparam logic [1:0] ST_DONE    = 2'd2;
  localparam logic [1:0] ST_DESTROY = 2'd3;

  localparam logic [2:0] RC_OK        = 3'd0;
  localparam logic [2:0] RC_FULL      = 3'd1;
  localparam logic [2:0] RC_NOT_FOUND = 3'd2;
  localparam logic [2:0] RC_DONE      = 3'd3;
  localparam logic [2:0] RC_NONE      = 3'd4;

  typedef enum logic [3:0] {
    OP_HOLD,
    OP_INSERT,
    OP_WAKE,
    OP_CLEAN,
    OP_COMPACT,
    OP_SCAN_RUN,
    OP_SCAN_ID,
    OP_MARK_DESTROY,
    OP_SET_JOINER
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     phase;
  } cell_cmd_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CREATE,
    S_EXIT,
    S_CLEAN,
    S_COMPACT,
    S_PSCAN,
    S_JSCAN,
    S_JMARK,
    S_JBLK,
    S_INSERT,
    S_RESP
  } state_t;

endpackage

>>> rtl/core/lets_cell.sv
// ----------------------------------------------------------------------------
// Queue cell
// One ready-queue slot: holds a thread record, shifts for ordered insert,
// swaps holes toward the tail and passes the search token on.
// ----------------------------------------------------------------------------
module lets_cell #(
  parameter int MAX_THREADS  = lets_pkg::LETS_MAX_THREADS,
  parameter int ELAPSED_BITS = lets_pkg::LETS_ELAPSED_BITS,
  parameter bit PARITY       = 1'b0
) (
  input  logic                                     clk,
  input  logic                                     rst_n,
  input  lets_pkg::cell_cmd_t                      cmd,
  input  logic [2*$clog2(MAX_THREADS)+ELAPSED_BITS+3:0] key,
  input  logic [2*$clog2(MAX_THREADS)+ELAPSED_BITS+3:0] left_rec,
  input  logic [2*$clog2(MAX_THREADS)+ELAPSED_BITS+3:0] right_rec,
  input  logic                                     left_flag,
  input  logic [2*$clog2(MAX_THREADS)+ELAPSED_BITS+5:0] tok_in,
  output logic [2*$clog2(MAX_THREADS)+ELAPSED_BITS+3:0] rec_o,
  output logic                                     flag_o,
  output logic [2*$clog2(MAX_THREADS)+ELAPSED_BITS+5:0] tok_o
);
  import lets_pkg::*;

  localparam int ID_W = $clog2(MAX_THREADS);

  typedef struct packed {
    logic                    vld;
    logic [ID_W-1:0]         id;
    logic [1:0]              st;
    logic [ELAPSED_BITS-1:0] el;
    logic [ID_W-1:0]         blk;
    logic                    jw;
  } rec_t;

  typedef struct packed {
    logic act;
    logic found;
    rec_t rec;
  } tok_t;

  rec_t rec_r, rec_nxt, lt, rt, k;
  tok_t tok_r, tok_nxt, ti;
  logic flag, scan, cond, hit;

  assign lt = left_rec;
  assign rt = right_rec;
  assign k  = key;
  assign ti = tok_in;

  assign flag = !rec_r.vld || (k.el < rec_r.el);
  assign scan = (cmd.op == OP_SCAN_RUN) || (cmd.op == OP_SCAN_ID);
  assign cond = (cmd.op == OP_SCAN_RUN) ? (rec_r.st == ST_RUN) : (rec_r.id == k.id);
  assign hit  = scan && ti.act && !ti.found && rec_r.vld && cond;

  always_comb begin
    rec_nxt = rec_r;
    unique case (cmd.op)
      OP_HOLD: begin
      end
      OP_INSERT: begin
        if (flag) begin
          rec_nxt = left_flag ? lt : k;
        end
      end
      OP_WAKE: begin
        if (rec_r.vld && rec_r.st == ST_BLOCK && rec_r.blk == k.id) begin
          rec_nxt.st = ST_RUN;
        end
      end
      OP_CLEAN: begin
        if (rec_r.st == ST_DESTROY) begin
          rec_nxt.vld = 1'b0;
        end
      end
      OP_COMPACT: begin
        if (cmd.phase == PARITY) begin
          if (!rec_r.vld && rt.vld) begin
            rec_nxt = rt;
          end
        end else begin
          if (!lt.vld && rec_r.vld) begin
            rec_nxt = lt;
          end
        end
      end
      OP_SCAN_RUN: begin
        if (hit) begin
          rec_nxt.vld = 1'b0;
        end
      end
      OP_SCAN_ID: begin
      end
      OP_MARK_DESTROY: begin
        if (rec_r.vld && rec_r.id == k.id) begin
          rec_nxt.st = ST_DESTROY;
        end
      end
      OP_SET_JOINER: begin
        if (rec_r.vld && rec_r.id == k.id) begin
          rec_nxt.jw = k.jw;
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    tok_nxt.act   = scan && ti.act;
    tok_nxt.found = scan && ti.act && (ti.found || hit);
    tok_nxt.rec   = hit ? rec_r : ti.rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rec_r.vld   <= 1'b0;
      tok_r.act   <= 1'b0;
      tok_r.found <= 1'b0;
    end else begin
      rec_r <= rec_nxt;
      tok_r <= tok_nxt;
    end
  end

  assign rec_o  = rec_r;
  assign flag_o = flag;
  assign tok_o  = tok_r;

endmodule

>>> rtl/core/least_elapsed_thread_scheduler.sv
// ----------------------------------------------------------------------------
// Least elapsed thread scheduler
// Ready queue ordered by elapsed quanta, held in a row of queue cells.
// ----------------------------------------------------------------------------
// Events enter on the in_ stream: tuser carries the event kind (create,
// schedule, exit, join), tdata the join target and the wants-value flag.
// Each event yields one result word on the out_ stream: running thread,
// new thread id, status code and a switch flag.
// One event is handled at a time. A scheduling decision sweeps the cell row
// three times when it finds a run thread (hole compaction, run-thread
// search, compaction again) and twice when it finds none; schedule, exit
// and a join that blocks each make one such decision.
// A result waits in the output register while the next event is taken,
// so a stalled receiver costs nothing until a second result is ready.
// After reset thread 0 runs, the queue is empty and the next id is 1;
// the block is ready for an event as soon as reset is released.
module least_elapsed_thread_scheduler #(
  parameter int MAX_THREADS  = lets_pkg::LETS_MAX_THREADS,
  parameter int ELAPSED_BITS = lets_pkg::LETS_ELAPSED_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // target_id[3:0], wants_value[4]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata   // running_id[3:0], new_id[7:4],
                                  // status_code[10:8], switched[11]
);
  import lets_pkg::*;
  `include "assert_macros.svh"

  localparam int ID_W  = $clog2(MAX_THREADS);
  localparam int NID_W = $clog2(MAX_THREADS + 1);
  localparam int CNT_W = $clog2(MAX_THREADS);
  localparam int REC_W = 2 * ID_W + ELAPSED_BITS + 4;
  localparam int TOK_W = REC_W + 2;

  typedef struct packed {
    logic                    vld;
    logic [ID_W-1:0]         id;
    logic [1:0]              st;
    logic [ELAPSED_BITS-1:0] el;
    logic [ID_W-1:0]         blk;
    logic                    jw;
  } rec_t;

  typedef struct packed {
    logic act;
    logic found;
    rec_t rec;
  } tok_t;

  logic [REC_W-1:0] rec_w  [MAX_THREADS];
  logic             flag_w [MAX_THREADS];
  logic [TOK_W-1:0] tok_w  [MAX_THREADS];

  cell_cmd_t  cmd;
  rec_t       key, bound_l, bound_r;
  tok_t       tok0, tok_last;

  state_t            state_r, state_nxt;
  rec_t              cur_r, cur_nxt, pick_r, pick_nxt;
  logic [NID_W-1:0]  nid_r, nid_nxt;
  logic [ID_W-1:0]   tgt_r, tgt_nxt;
  logic              wants_r, wants_nxt;
  logic              second_r, second_nxt;
  logic              inj_r, inj_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [3:0]        rnew_r, rnew_nxt;
  logic [2:0]        rstat_r, rstat_nxt;
  logic              rsw_r, rsw_nxt;
  logic              ov_r, ov_nxt;
  logic [15:0]       od_r, od_nxt;

  assign bound_l  = '{vld: 1'b1, default: '0};
  assign bound_r  = '0;
  assign tok_last = tok_w[MAX_THREADS-1];

  for (genvar i = 0; i < MAX_THREADS; i++) begin : g_cell
    logic [REC_W-1:0] lrec, rrec;
    logic             lflag;
    logic [TOK_W-1:0] tin;
    if (i == 0) begin : g_head
      assign lrec  = bound_l;
      assign lflag = 1'b0;
      assign tin   = tok0;
    end else begin : g_body
      assign lrec  = rec_w[i-1];
      assign lflag = flag_w[i-1];
      assign tin   = tok_w[i-1];
    end
    if (i == MAX_THREADS - 1) begin : g_tail
      assign rrec = bound_r;
    end else begin : g_mid
      assign rrec = rec_w[i+1];
    end
    lets_cell #(
      .MAX_THREADS  (MAX_THREADS),
      .ELAPSED_BITS (ELAPSED_BITS),
      .PARITY       (1'(i % 2))
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .cmd       (cmd),
      .key       (key),
      .left_rec  (lrec),
      .right_rec (rrec),
      .left_flag (lflag),
      .tok_in    (tin),
      .rec_o     (rec_w[i]),
      .flag_o    (flag_w[i]),
      .tok_o     (tok_w[i])
    );
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = ov_r;
  assign out_tdata  = od_r;

  always_comb begin
    state_nxt  = state_r;
    cur_nxt    = cur_r;
    pick_nxt   = pick_r;
    nid_nxt    = nid_r;
    tgt_nxt    = tgt_r;
    wants_nxt  = wants_r;
    second_nxt = second_r;
    inj_nxt    = inj_r;
    cnt_nxt    = cnt_r;
    rnew_nxt   = rnew_r;
    rstat_nxt  = rstat_r;
    rsw_nxt    = rsw_r;
    ov_nxt     = ov_r && !out_tready;
    od_nxt     = od_r;
    cmd        = '{op: OP_HOLD, phase: 1'b0};
    key        = '0;
    tok0       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          tgt_nxt   = ID_W'(in_tdata[3:0]);
          wants_nxt = in_tdata[4];
          rnew_nxt  = 4'd0;
          rstat_nxt = RC_OK;
          rsw_nxt   = 1'b0;
          inj_nxt   = 1'b0;
          unique case (in_tuser)
            FN_CREATE: state_nxt = S_CREATE;
            FN_SCHED:  state_nxt = S_CLEAN;
            FN_EXIT:   state_nxt = S_EXIT;
            FN_JOIN: begin
              if (32'(in_tdata[3:0]) < 32'(MAX_THREADS)) begin
                state_nxt = S_JSCAN;
              end else begin
                rstat_nxt = RC_NOT_FOUND;
                state_nxt = S_RESP;
              end
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_CREATE: begin
        if (nid_r == NID_W'(MAX_THREADS)) begin
          rstat_nxt = RC_FULL;
        end else begin
          cmd.op   = OP_INSERT;
          key.vld  = 1'b1;
          key.id   = nid_r[ID_W-1:0];
          key.st   = ST_RUN;
          rnew_nxt = 4'(nid_r);
          nid_nxt  = nid_r + NID_W'(1);
        end
        state_nxt = S_RESP;
      end
      S_EXIT: begin
        cur_nxt.st = cur_r.jw ? ST_DESTROY : ST_DONE;
        cmd.op     = OP_WAKE;
        key.id     = cur_r.id;
        state_nxt  = S_CLEAN;
      end
      S_CLEAN: begin
        cmd.op     = OP_CLEAN;
        cnt_nxt    = '0;
        second_nxt = 1'b0;
        state_nxt  = S_COMPACT;
      end
      S_COMPACT: begin
        cmd.op    = OP_COMPACT;
        cmd.phase = cnt_r[0];
        cnt_nxt   = cnt_r + CNT_W'(1);
        if (cnt_r == CNT_W'(MAX_THREADS - 1)) begin
          cnt_nxt   = '0;
          inj_nxt   = 1'b0;
          state_nxt = second_r ? S_INSERT : S_PSCAN;
        end
      end
      S_PSCAN: begin
        cmd.op   = OP_SCAN_RUN;
        tok0.act = !inj_r;
        inj_nxt  = 1'b1;
        if (tok_last.act) begin
          if (tok_last.found) begin
            pick_nxt   = tok_last.rec;
            cur_nxt.el = (&cur_r.el) ? cur_r.el : cur_r.el + ELAPSED_BITS'(1);
            second_nxt = 1'b1;
            state_nxt  = S_COMPACT;
          end else begin
            rstat_nxt = RC_NONE;
            state_nxt = S_RESP;
          end
        end
      end
      S_JSCAN: begin
        cmd.op   = OP_SCAN_ID;
        key.id   = tgt_r;
        tok0.act = !inj_r;
        inj_nxt  = 1'b1;
        if (tok_last.act) begin
          if (!tok_last.found || tok_last.rec.st == ST_DESTROY) begin
            rstat_nxt = RC_NOT_FOUND;
            state_nxt = S_RESP;
          end else if (tok_last.rec.st == ST_DONE) begin
            rstat_nxt = RC_DONE;
            state_nxt = wants_r ? S_JMARK : S_RESP;
          end else begin
            cur_nxt.st  = ST_BLOCK;
            cur_nxt.blk = tgt_r;
            state_nxt   = S_JBLK;
          end
        end
      end
      S_JMARK: begin
        cmd.op    = OP_MARK_DESTROY;
        key.id    = tgt_r;
        state_nxt = S_RESP;
      end
      S_JBLK: begin
        cmd.op    = OP_SET_JOINER;
        key.id    = tgt_r;
        key.jw    = wants_r;
        state_nxt = S_CLEAN;
      end
      S_INSERT: begin
        cmd.op    = OP_INSERT;
        key       = cur_r;
        key.vld   = 1'b1;
        cur_nxt   = pick_r;
        rsw_nxt   = 1'b1;
        state_nxt = S_RESP;
      end
      S_RESP: begin
        if (!ov_r || out_tready) begin
          ov_nxt    = 1'b1;
          od_nxt    = {4'd0, rsw_r, rstat_r, rnew_r, 4'(cur_r.id)};
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      cur_r    <= '{vld: 1'b1, st: ST_RUN, default: '0};
      nid_r    <= NID_W'(1);
      second_r <= 1'b0;
      inj_r    <= 1'b0;
      cnt_r    <= '0;
      ov_r     <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cur_r    <= cur_nxt;
      nid_r    <= nid_nxt;
      second_r <= second_nxt;
      inj_r    <= inj_nxt;
      cnt_r    <= cnt_nxt;
      ov_r     <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pick_r  <= pick_nxt;
    tgt_r   <= tgt_nxt;
    wants_r <= wants_nxt;
    rnew_r  <= rnew_nxt;
    rstat_r <= rstat_nxt;
    rsw_r   <= rsw_nxt;
    od_r    <= od_nxt;
  end

  `LETS_ASSERT(a_nid_range, clk, rst_n, (nid_r != '0) && (nid_r <= NID_W'(MAX_THREADS)))
  `LETS_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, in_tvalid && in_tready, state_r != S_IDLE)
  `LETS_ASSERT(a_switch_is_ok, clk, rst_n, !(ov_r && od_r[11]) || (od_r[10:8] == RC_OK))

endmodule
